### src/sts_pkg.sv
// Package for the SQL token scanner: token kinds, sizing constants, the
// keyword table and the byte-class helpers. No dependencies.
`default_nettype none

package sts_pkg;

    // Sizing constants.
    localparam int MAX_STATEMENT_BYTES = 4096;
    localparam int TOKEN_LENGTH_LIMIT  = 255;
    localparam int POS_W               = $clog2(MAX_STATEMENT_BYTES);
    localparam int RUN_W               = $clog2(TOKEN_LENGTH_LIMIT + 1);
    localparam int PREFIX_DEPTH        = 9;
    localparam int PREFIX_BITS         = 8 * PREFIX_DEPTH;
    localparam int IDX_W               = $clog2(PREFIX_DEPTH + 1);
    localparam int NUM_KW              = 30;
    localparam int FIFO_DEPTH          = 4;
    localparam int FPTR_W              = $clog2(FIFO_DEPTH);
    localparam int FCNT_W              = $clog2(FIFO_DEPTH + 1);

    // Field widths of a result.
    localparam int KIND_W  = 6;
    localparam int START_W = 12;
    localparam int LEN_W   = 8;

    // Token kinds.
    localparam logic [KIND_W-1:0] K_ERROR  = 6'd0;
    localparam logic [KIND_W-1:0] K_IDENT  = 6'd31;
    localparam logic [KIND_W-1:0] K_NUMBER = 6'd32;
    localparam logic [KIND_W-1:0] K_LT     = 6'd33;
    localparam logic [KIND_W-1:0] K_LE     = 6'd34;
    localparam logic [KIND_W-1:0] K_GT     = 6'd35;
    localparam logic [KIND_W-1:0] K_GE     = 6'd36;
    localparam logic [KIND_W-1:0] K_EQ     = 6'd37;
    localparam logic [KIND_W-1:0] K_NE     = 6'd38;
    localparam logic [KIND_W-1:0] K_AMP    = 6'd39;
    localparam logic [KIND_W-1:0] K_LPAR   = 6'd40;
    localparam logic [KIND_W-1:0] K_RPAR   = 6'd41;
    localparam logic [KIND_W-1:0] K_STAR   = 6'd42;
    localparam logic [KIND_W-1:0] K_SEMI   = 6'd43;
    localparam logic [KIND_W-1:0] K_COMMA  = 6'd44;
    localparam logic [KIND_W-1:0] K_DOT    = 6'd45;
    localparam logic [KIND_W-1:0] K_PIPE   = 6'd46;
    localparam logic [KIND_W-1:0] K_MINUS  = 6'd47;
    localparam logic [KIND_W-1:0] K_COLON  = 6'd48;
    localparam logic [KIND_W-1:0] K_END    = 6'd49;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // Keywords, first character in the top byte, padded with zero bytes.
    localparam logic [PREFIX_BITS-1:0] KW_TABLE [NUM_KW] = '{
        {"select", 24'h0}, {"insert", 24'h0}, {"delete", 24'h0},
        {"from", 40'h0}, {"into", 40'h0}, {"where", 32'h0},
        {"group", 32'h0}, {"by", 56'h0}, {"between", 16'h0},
        {"and", 48'h0}, {"or", 56'h0}, {"primary", 16'h0},
        {"like", 40'h0}, {"values", 24'h0}, {"order", 32'h0},
        {"mean", 40'h0}, {"max", 48'h0}, {"min", 48'h0},
        {"count", 32'h0}, {"as", 56'h0}, {"time", 40'h0},
        {"create", 24'h0}, {"database", 8'h0}, {"table", 32'h0},
        {"use", 48'h0}, {"int", 48'h0}, {"float", 32'h0},
        {"double", 24'h0}, {"timestamp"}, {"varchar", 16'h0}
    };

    // One result as it waits in the output queue.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start_res;
        logic [LEN_W-1:0]   length;
        logic               too_long;
        logic               last;
    } token_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Keyword code of a short run, or identifier when nothing matches.
    function automatic logic [KIND_W-1:0] kw_lookup(input logic [PREFIX_BITS-1:0] p);
        logic [KIND_W-1:0] r;
        r = K_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            if (p == KW_TABLE[k]) begin
                r = KIND_W'(k + 1);
            end
        end
        return r;
    endfunction

    // Kind of a single-character symbol; anything unlisted is an error.
    function automatic logic [KIND_W-1:0] symbol_kind(input logic [7:0] c);
        logic [KIND_W-1:0] r;
        case (c)
            8'h3D:   r = K_EQ;
            8'h26:   r = K_AMP;
            8'h28:   r = K_LPAR;
            8'h29:   r = K_RPAR;
            8'h2A:   r = K_STAR;
            8'h3B:   r = K_SEMI;
            8'h2C:   r = K_COMMA;
            8'h2E:   r = K_DOT;
            8'h7C:   r = K_PIPE;
            8'h2D:   r = K_MINUS;
            8'h3A:   r = K_COLON;
            default: r = K_ERROR;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### src/sql_token_scanner_unit.sv
// Results: the tokens that an accepted byte completes enter the result queue when that
// byte is accepted and leave in order on the m_ ports; a run token waits for the byte that ends it.
// Throughput: one byte per cycle while s_ready is high. Two tokens from one byte leave one after the other.
// s_ready is low while the four-entry result queue has fewer than two free entries.
// Reset (aresetn low at a clock edge): scanner idle, offset zero, result queue empty.
`default_nettype none

module sql_token_scanner_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [7:0]                 s_ch,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [sts_pkg::KIND_W-1:0]      m_kind,
    output logic [sts_pkg::START_W-1:0]     m_start_res,
    output logic [sts_pkg::LEN_W-1:0]       m_length,
    output logic                            m_too_long,
    output logic                            m_last
);
    import sts_pkg::*;

    // Scanner mode: idle between tokens, inside a run, or holding a character
    // that may pair with a following '='.
    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_LT,
        M_GT,
        M_BANG
    } mode_t;

    // Scanner state.
    mode_t                    mode_reg, mode_next;
    logic [PREFIX_BITS-1:0]   prefix_reg, prefix_next;
    logic [RUN_W-1:0]         run_len_reg, run_len_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [POS_W-1:0]         tok_start_reg, tok_start_next;
    logic                     ovf_reg, ovf_next;

    // Result queue.
    token_t                   fifo_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [FCNT_W-1:0]        count_reg;

    // Up to two results from the byte on s_ch.
    token_t                   res [2];
    logic [1:0]               n_res;

    logic                     accept;
    logic                     pop;

    // A new byte is taken whenever the queue has room for both of its
    // possible results; this does not depend on the result side.
    assign s_ready = (count_reg <= FCNT_W'(FIFO_DEPTH - 2));
    assign accept  = s_valid && s_ready;

    assign m_valid     = (count_reg != '0);
    assign pop         = m_valid && m_ready;
    assign m_kind      = fifo_reg[rd_ptr_reg].kind;
    assign m_start_res = fifo_reg[rd_ptr_reg].start_res;
    assign m_length    = fifo_reg[rd_ptr_reg].length;
    assign m_too_long  = fifo_reg[rd_ptr_reg].too_long;
    assign m_last      = fifo_reg[rd_ptr_reg].last;

    // Single-pass scan of one byte. The token that the byte closes, if any, comes first;
    // a byte that closes a token without pairing with it is then scanned as if nothing were pending.
    always_comb begin
        token_t             pend;
        token_t             fresh;
        logic               pend_v;
        logic               fresh_v;
        logic               rescan;
        logic               extend;
        logic [KIND_W-1:0]  run_kind;

        mode_next      = mode_reg;
        prefix_next    = prefix_reg;
        run_len_next   = run_len_reg;
        pos_next       = pos_reg;
        tok_start_next = tok_start_reg;
        ovf_next       = ovf_reg;

        pend     = '0;
        fresh    = '0;
        pend_v   = 1'b0;
        fresh_v  = 1'b0;
        rescan   = 1'b0;
        extend   = 1'b0;

        // A run longer than the prefix can never be a keyword.
        if (ovf_reg || (run_len_reg > RUN_W'(PREFIX_DEPTH))) begin
            run_kind = K_IDENT;
        end else begin
            run_kind = kw_lookup(prefix_reg);
        end

        pend.start_res = START_W'(tok_start_reg);

        unique case (mode_reg)
            M_IDENT: begin
                if (is_letter(s_ch) || is_digit(s_ch)) begin
                    extend = 1'b1;
                end else begin
                    pend_v        = 1'b1;
                    pend.kind     = run_kind;
                    pend.length   = LEN_W'(run_len_reg);
                    pend.too_long = ovf_reg;
                    rescan        = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_digit(s_ch)) begin
                    extend = 1'b1;
                end else begin
                    pend_v        = 1'b1;
                    pend.kind     = K_NUMBER;
                    pend.length   = LEN_W'(run_len_reg);
                    pend.too_long = ovf_reg;
                    rescan        = 1'b1;
                end
            end
            M_LT, M_GT, M_BANG: begin
                pend_v = 1'b1;
                if (s_ch == CH_EQ) begin
                    pend.kind   = (mode_reg == M_LT) ? K_LE :
                                  (mode_reg == M_GT) ? K_GE : K_NE;
                    pend.length = LEN_W'(2);
                    mode_next   = M_IDLE;
                end else begin
                    // A '!' on its own is an error token.
                    pend.kind   = (mode_reg == M_LT) ? K_LT :
                                  (mode_reg == M_GT) ? K_GT : K_ERROR;
                    pend.length = LEN_W'(1);
                    rescan      = 1'b1;
                end
            end
            default: begin
                rescan = 1'b1;
            end
        endcase

        // Extend the current run; the length stops at the limit and the
        // overflow flag records that bytes were lost.
        if (extend) begin
            if (run_len_reg < RUN_W'(TOKEN_LENGTH_LIMIT)) begin
                for (int i = 1; i < PREFIX_DEPTH; i++) begin
                    if (run_len_reg == RUN_W'(i)) begin
                        prefix_next[PREFIX_BITS-1-8*i -: 8] = s_ch;
                    end
                end
                run_len_next = run_len_reg + RUN_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end

        fresh.start_res = START_W'(pos_reg);

        if (rescan) begin
            mode_next = M_IDLE;
            if (s_ch == CH_SPACE) begin
                mode_next = M_IDLE;
            end else if (is_letter(s_ch) || is_digit(s_ch)) begin
                prefix_next                               = '0;
                prefix_next[PREFIX_BITS-1 -: 8]           = s_ch;
                run_len_next                              = RUN_W'(1);
                ovf_next                                  = 1'b0;
                tok_start_next                            = pos_reg;
                mode_next = is_letter(s_ch) ? M_IDENT : M_NUMBER;
            end else if ((s_ch == CH_LT) || (s_ch == CH_GT) || (s_ch == CH_BANG)) begin
                tok_start_next = pos_reg;
                mode_next = (s_ch == CH_LT) ? M_LT : (s_ch == CH_GT) ? M_GT : M_BANG;
            end else if (s_ch == CH_NUL) begin
                fresh_v      = 1'b1;
                fresh.kind   = K_END;
                fresh.length = '0;
            end else begin
                fresh_v      = 1'b1;
                fresh.kind   = symbol_kind(s_ch);
                fresh.length = LEN_W'(1);
            end
        end

        // The end of a statement restarts the scanner; otherwise the offset
        // advances and holds at the last offset of the longest statement.
        if (s_ch == CH_NUL) begin
            mode_next = M_IDLE;
            pos_next  = '0;
        end else if (pos_reg != POS_W'(MAX_STATEMENT_BYTES - 1)) begin
            pos_next = pos_reg + POS_W'(1);
        end

        // Pack the results in order and mark the final one.
        if (pend_v) begin
            res[0]      = pend;
            res[1]      = fresh;
            res[0].last = !fresh_v;
            res[1].last = 1'b1;
        end else begin
            res[0]      = fresh;
            res[1]      = '0;
            res[0].last = 1'b1;
        end
        n_res = 2'(pend_v) + 2'(fresh_v);
    end

    // Scanner state and result queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= M_IDLE;
            prefix_reg    <= '0;
            run_len_reg   <= '0;
            pos_reg       <= '0;
            tok_start_reg <= '0;
            ovf_reg       <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end else begin
            if (accept) begin
                mode_reg      <= mode_next;
                prefix_reg    <= prefix_next;
                run_len_reg   <= run_len_next;
                pos_reg       <= pos_next;
                tok_start_reg <= tok_start_next;
                ovf_reg       <= ovf_next;
                if (n_res != 2'd0) begin
                    fifo_reg[wr_ptr_reg] <= res[0];
                end
                if (n_res == 2'd2) begin
                    fifo_reg[wr_ptr_reg + FPTR_W'(1)] <= res[1];
                end
                wr_ptr_reg <= wr_ptr_reg + FPTR_W'(n_res);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FPTR_W'(1);
            end
            count_reg <= count_reg + (accept ? FCNT_W'(n_res) : FCNT_W'(0))
                         - FCNT_W'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    // The queue never holds more results than it has entries.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("result queue over-filled");

    // A NUL byte sends the scanner back to the idle mode at offset zero.
    a_nul_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_ch == CH_NUL)) |=> ((pos_reg == '0) && (mode_reg == M_IDLE)))
        else $error("scanner not restarted after end of statement");

    // Overflow is only ever flagged on a run that has reached the limit.
    a_ovf_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (run_len_reg == RUN_W'(TOKEN_LENGTH_LIMIT)))
        else $error("overflow flag set below the length limit");

    // An accepted byte that yields a result leaves at least one result queued.
    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (n_res != 2'd0)) |=> m_valid)
        else $error("token lost from the result queue");
`endif

endmodule

`default_nettype wire
